@@ sv/uart_command_line_parser_assert.svh @@
// Assertion macros used by the parser datapath
`ifndef UART_COMMAND_LINE_PARSER_ASSERT_SVH
`define UART_COMMAND_LINE_PARSER_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define UCLP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle brings another in the next cycle
`define UCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/uclp_pkg.sv @@
// Types, codes and keyword tables of the command line parser
package uclp_pkg;

    // Action codes
    localparam logic [3:0] ACT_PONG     = 4'd0;
    localparam logic [3:0] ACT_HELP     = 4'd1;
    localparam logic [3:0] ACT_STATUS   = 4'd2;
    localparam logic [3:0] ACT_DRIVE    = 4'd3;
    localparam logic [3:0] ACT_PIN      = 4'd4;
    localparam logic [3:0] ACT_MAP      = 4'd5;
    localparam logic [3:0] ACT_UNKNOWN  = 4'd6;
    localparam logic [3:0] ACT_BLANK    = 4'd7;
    localparam logic [3:0] ACT_LONG     = 4'd8;
    localparam logic [3:0] ACT_SENTENCE = 4'd9;

    // Drive modes
    localparam logic [2:0] MODE_STOP    = 3'd0;
    localparam logic [2:0] MODE_FORWARD = 3'd1;
    localparam logic [2:0] MODE_REVERSE = 3'd2;
    localparam logic [2:0] MODE_LEFT    = 3'd3;
    localparam logic [2:0] MODE_RIGHT   = 3'd4;

    // Byte codes
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_ZERO   = "0";
    localparam logic [7:0] CHR_DOLLAR = "$";
    localparam logic [7:0] CHR_COMMA  = ",";

    // Keyword table: words left-aligned in 8 bytes, zero padded
    localparam int KW_COUNT = 25;
    typedef logic [63:0] kw_word_t;

    localparam kw_word_t KW_WORD [KW_COUNT] = '{
        {"PING", 32'd0}, {"HELP", 32'd0}, {"?", 56'd0}, {"Q", 56'd0},
        {"STATUS", 16'd0}, {"STOP", 32'd0}, {"X", 56'd0}, {"0", 56'd0},
        {"F", 56'd0}, {"FORWARD", 8'd0}, {"B", 56'd0}, {"BACK", 32'd0},
        "BACKWARD", {"REVERSE", 8'd0}, {"L", 56'd0}, {"LEFT", 32'd0},
        {"R", 56'd0}, {"RIGHT", 24'd0}, {"T", 56'd0}, {"PINTEST", 8'd0},
        "GPIOTEST", {"C", 56'd0}, {"MAPTEST", 8'd0}, {"PINMAP", 16'd0},
        {"M", 56'd0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd4, 4'd1, 4'd1, 4'd6, 4'd4, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1, 4'd4,
        4'd8, 4'd7, 4'd1, 4'd4, 4'd1, 4'd5, 4'd1, 4'd7, 4'd8, 4'd1, 4'd7, 4'd6,
        4'd1
    };

    localparam logic [3:0] KW_ACT [KW_COUNT] = '{
        ACT_PONG, ACT_HELP, ACT_HELP, ACT_STATUS, ACT_STATUS,
        ACT_DRIVE, ACT_DRIVE, ACT_DRIVE, ACT_DRIVE, ACT_DRIVE,
        ACT_DRIVE, ACT_DRIVE, ACT_DRIVE, ACT_DRIVE, ACT_DRIVE,
        ACT_DRIVE, ACT_DRIVE, ACT_DRIVE, ACT_PIN, ACT_PIN,
        ACT_PIN, ACT_MAP, ACT_MAP, ACT_MAP, ACT_MAP
    };

    localparam logic [2:0] KW_MODE [KW_COUNT] = '{
        MODE_STOP, MODE_STOP, MODE_STOP, MODE_STOP, MODE_STOP,
        MODE_STOP, MODE_STOP, MODE_STOP, MODE_FORWARD, MODE_FORWARD,
        MODE_REVERSE, MODE_REVERSE, MODE_REVERSE, MODE_REVERSE, MODE_LEFT,
        MODE_LEFT, MODE_RIGHT, MODE_RIGHT, MODE_STOP, MODE_STOP,
        MODE_STOP, MODE_STOP, MODE_STOP, MODE_STOP, MODE_STOP
    };

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LREAD,
        ST_LWAIT,
        ST_LDONE,
        ST_LOUT,
        ST_CHAR,
        ST_CDONE,
        ST_FOUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;
        logic scan_clear;
        logic rd_start;
        logic rd_issue;
        logic feed_char;
        logic store;
        logic fill_clear;
        logic emit;
        logic emit_last;
        logic emit_long;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic quick;
        logic zero_char;
        logic eol;
        logic fill_empty;
        logic fill_full;
        logic rd_last;
        logic out_taken;
    } status_t;

    // Fold lower case letters to upper case
    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // Space or a control code from tab to carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Letters that act at once
    function automatic logic is_quick(input logic [7:0] c);
        logic [7:0] u;
        u = fold(c);
        return u == "F" || u == "B" || u == "L" || u == "R" ||
               u == "T" || u == "C" || u == "X";
    endfunction

endpackage

@@ sv/uart_command_line_parser.sv @@
// Top level of the serial command line parser
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   rx_byte[7:0]
//  output   out        out_valid/out_stall action[3:0] drive_mode[2:0] mode_changed last_result
//
// A byte is stored, or an empty line end dropped, without a result; a one-letter command is scanned alone.
// A flush reads the line store one entry a cycle, up to the fill count.
// One item is worked at a time; input stalls until its last result is taken.
// Reset clears the fill count, mode (stop) and controller; the line store is not cleared.
// An output stall holds the result and the whole block until it is taken.
module uart_command_line_parser
#(
    parameter int LINE_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] action,
    output logic [2:0] drive_mode,
    output logic       mode_changed,
    output logic       last_result
);

    uclp_pkg::cmd_t    cmd;
    uclp_pkg::status_t st;

    uclp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    uclp_datapath #(.LINE_DEPTH(LINE_DEPTH)) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .drive_mode   (drive_mode),
        .mode_changed (mode_changed),
        .last_result  (last_result)
    );

endmodule

@@ sv/uclp_ctrl.sv @@
// Sequencing state machine of the command line parser
module uclp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  uclp_pkg::status_t st,
    output uclp_pkg::cmd_t    cmd
);

    uclp_pkg::state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uclp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose the next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            uclp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = uclp_pkg::ST_DECIDE;
                end
            end
            uclp_pkg::ST_DECIDE:
            begin
                priority if ((st.quick || st.eol) && !st.fill_empty)
                begin
                    state_next = uclp_pkg::ST_LREAD;
                end
                else if (st.quick || (st.zero_char && st.fill_empty))
                begin
                    state_next = uclp_pkg::ST_CHAR;
                end
                else if (st.eol || !st.fill_full)
                begin
                    state_next = uclp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = uclp_pkg::ST_FOUT;
                end
            end
            uclp_pkg::ST_LREAD:
            begin
                if (st.rd_last)
                begin
                    state_next = uclp_pkg::ST_LWAIT;
                end
            end
            uclp_pkg::ST_LWAIT: state_next = uclp_pkg::ST_LDONE;
            uclp_pkg::ST_LDONE: state_next = uclp_pkg::ST_LOUT;
            uclp_pkg::ST_LOUT:
            begin
                if (st.out_taken)
                begin
                    state_next = st.quick ? uclp_pkg::ST_CHAR : uclp_pkg::ST_IDLE;
                end
            end
            uclp_pkg::ST_CHAR:  state_next = uclp_pkg::ST_CDONE;
            uclp_pkg::ST_CDONE: state_next = uclp_pkg::ST_FOUT;
            uclp_pkg::ST_FOUT:
            begin
                if (st.out_taken)
                begin
                    state_next = uclp_pkg::ST_IDLE;
                end
            end
            default: state_next = uclp_pkg::ST_IDLE;
        endcase
    end

    // Drive the datapath commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            uclp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            uclp_pkg::ST_DECIDE:
            begin
                priority if ((st.quick || st.eol) && !st.fill_empty)
                begin
                    cmd.scan_clear = 1'b1;
                    cmd.rd_start   = 1'b1;
                end
                else if (st.quick || (st.zero_char && st.fill_empty))
                begin
                    cmd.scan_clear = 1'b1;
                end
                else if (st.eol)
                begin
                    cmd.scan_clear = 1'b0;
                end
                else if (!st.fill_full)
                begin
                    cmd.store = 1'b1;
                end
                else
                begin
                    cmd.fill_clear = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_long  = 1'b1;
                    cmd.emit_last  = 1'b1;
                end
            end
            uclp_pkg::ST_LREAD: cmd.rd_issue = 1'b1;
            uclp_pkg::ST_LWAIT: cmd.rd_issue = 1'b0;
            uclp_pkg::ST_LDONE:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_last  = !st.quick;
                cmd.fill_clear = 1'b1;
            end
            uclp_pkg::ST_LOUT:  cmd.scan_clear = st.out_taken && st.quick;
            uclp_pkg::ST_CHAR:  cmd.feed_char = 1'b1;
            uclp_pkg::ST_CDONE:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
            end
            uclp_pkg::ST_FOUT:  cmd.take = 1'b0;
            default:            cmd = '0;
        endcase
    end

endmodule

@@ sv/uclp_datapath.sv @@
// Line store, keyword scanner, mode register and output register
`include "uart_command_line_parser_assert.svh"

module uclp_datapath
#(
    parameter int LINE_DEPTH = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  uclp_pkg::cmd_t    cmd,
    output uclp_pkg::status_t st,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        action,
    output logic [2:0]        drive_mode,
    output logic              mode_changed,
    output logic              last_result
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int KN = uclp_pkg::KW_COUNT;
    localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

    logic [7:0]    line_mem [LINE_DEPTH];
    logic [7:0]    byte_reg;
    logic [AW-1:0] fill_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_vld_reg;
    logic [7:0]    mem_q_reg;
    logic [2:0]    mode_reg, mode_next;

    // Scanner state
    logic          ended_reg, ended_next;
    logic          seen_reg, seen_next;
    logic          dollar_reg, dollar_next;
    logic          comma_reg, comma_next;
    logic [3:0]    pos_reg, pos_next;
    logic [3:0]    tl_reg, tl_next;
    logic [KN-1:0] ok_reg, ok_next;

    // Output register
    logic          out_valid_reg;
    logic [3:0]    action_reg, action_next;
    logic          changed_reg, changed_next;
    logic          last_reg;

    logic          feed;
    logic [7:0]    feed_byte;
    logic [7:0]    feed_up;
    logic [KN-1:0] match;

    // Hold the received byte
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Write and read the line store
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            line_mem[fill_reg] <= byte_reg;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= line_mem[rd_addr_reg];
        end
    end

    // Advance the fill count and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.fill_clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.store)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.rd_start)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            rd_vld_reg <= cmd.rd_issue;
        end
    end

    // Report status of the held byte and the line
    always_comb
    begin
        st.quick      = uclp_pkg::is_quick(byte_reg);
        st.zero_char  = byte_reg == uclp_pkg::CHR_ZERO;
        st.eol        = byte_reg == uclp_pkg::CHR_CR || byte_reg == uclp_pkg::CHR_LF;
        st.fill_empty = fill_reg == '0;
        st.fill_full  = fill_reg == FILL_MAX;
        st.rd_last    = rd_addr_reg == fill_reg - 1'b1;
        st.out_taken  = out_valid_reg && !out_stall;
    end

    // Feed one byte a cycle through the keyword scanner
    assign feed      = rd_vld_reg || cmd.feed_char;
    assign feed_byte = cmd.feed_char ? byte_reg : mem_q_reg;
    assign feed_up   = uclp_pkg::fold(feed_byte);

    always_comb
    begin
        ended_next  = ended_reg;
        seen_next   = seen_reg;
        dollar_next = dollar_reg;
        comma_next  = comma_reg;
        pos_next    = pos_reg;
        tl_next     = tl_reg;
        ok_next     = ok_reg;
        if (cmd.scan_clear)
        begin
            ended_next  = 1'b0;
            seen_next   = 1'b0;
            dollar_next = 1'b0;
            comma_next  = 1'b0;
            pos_next    = '0;
            tl_next     = '0;
            ok_next     = '1;
        end
        else if (feed && !ended_reg)
        begin
            if (feed_byte == uclp_pkg::CHR_NUL)
            begin
                ended_next = 1'b1;
            end
            else if (seen_reg || !uclp_pkg::is_ws(feed_byte))
            begin
                // Compare against each keyword at this position
                for (int k = 0; k < KN; k++)
                begin
                    if (pos_reg < uclp_pkg::KW_LEN[k])
                    begin
                        if (feed_up != uclp_pkg::KW_WORD[k][(7 - int'(pos_reg[2:0])) * 8 +: 8])
                        begin
                            ok_next[k] = 1'b0;
                        end
                    end
                    else if (!uclp_pkg::is_ws(feed_byte))
                    begin
                        ok_next[k] = 1'b0;
                    end
                end
                if (!uclp_pkg::is_ws(feed_byte))
                begin
                    seen_next = 1'b1;
                    tl_next   = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
                end
                if (pos_reg == 4'd0)
                begin
                    dollar_next = feed_byte == uclp_pkg::CHR_DOLLAR;
                end
                else if (feed_byte == uclp_pkg::CHR_COMMA)
                begin
                    comma_next = 1'b1;
                end
                pos_next = (pos_reg == 4'd15) ? pos_reg : pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg  <= 1'b0;
            seen_reg   <= 1'b0;
            dollar_reg <= 1'b0;
            comma_reg  <= 1'b0;
            pos_reg    <= '0;
            tl_reg     <= '0;
            ok_reg     <= '1;
        end
        else
        begin
            ended_reg  <= ended_next;
            seen_reg   <= seen_next;
            dollar_reg <= dollar_next;
            comma_reg  <= comma_next;
            pos_reg    <= pos_next;
            tl_reg     <= tl_next;
            ok_reg     <= ok_next;
        end
    end

    // Classify the scanned line
    always_comb
    begin
        for (int k = 0; k < KN; k++)
        begin
            match[k] = ok_reg[k] && (tl_reg == uclp_pkg::KW_LEN[k]);
        end
    end

    always_comb
    begin
        action_next  = uclp_pkg::ACT_UNKNOWN;
        mode_next    = mode_reg;
        changed_next = 1'b0;
        priority if (cmd.emit_long)
        begin
            action_next = uclp_pkg::ACT_LONG;
        end
        else if (!seen_reg)
        begin
            action_next = uclp_pkg::ACT_BLANK;
        end
        else if (dollar_reg && comma_reg)
        begin
            action_next = uclp_pkg::ACT_SENTENCE;
        end
        else
        begin
            // At most one keyword matches a given line
            for (int k = 0; k < KN; k++)
            begin
                if (match[k])
                begin
                    action_next = uclp_pkg::KW_ACT[k];
                    if (uclp_pkg::KW_ACT[k] == uclp_pkg::ACT_DRIVE ||
                        uclp_pkg::KW_ACT[k] == uclp_pkg::ACT_PIN ||
                        uclp_pkg::KW_ACT[k] == uclp_pkg::ACT_MAP)
                    begin
                        mode_next = uclp_pkg::KW_MODE[k];
                    end
                    if (uclp_pkg::KW_ACT[k] == uclp_pkg::ACT_DRIVE)
                    begin
                        changed_next = mode_reg != uclp_pkg::KW_MODE[k];
                    end
                end
            end
        end
    end

    // Load the result and the mode, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= uclp_pkg::MODE_STOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                mode_reg      <= mode_next;
                out_valid_reg <= 1'b1;
            end
            else if (st.out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            action_reg  <= action_next;
            changed_reg <= changed_next;
            last_reg    <= cmd.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign drive_mode   = mode_reg;
    assign mode_changed = changed_reg;
    assign last_result  = last_reg;

    // Checks
    `UCLP_ASSERT(a_fill_bound, fill_reg <= FILL_MAX, "fill count beyond line depth")
    `UCLP_ASSERT(a_no_overwrite, !(cmd.emit && out_valid_reg), "result overwritten before taken")
    `UCLP_ASSERT_NEXT(a_store_adv, cmd.store, fill_reg == $past(fill_reg) + 1'b1, "store did not advance fill")
    `UCLP_ASSERT_NEXT(a_read_in_line, cmd.rd_issue, rd_vld_reg && !st.fill_empty, "read beyond an empty line")

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench of the serial command line parser
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] mode;
        logic       changed;
        logic       last;
    } report_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] action;
    logic [2:0] drive_mode;
    logic       mode_changed;
    logic       last_result;

    uart_command_line_parser #(.LINE_DEPTH(LINE_DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .drive_mode   (drive_mode),
        .mode_changed (mode_changed),
        .last_result  (last_result)
    );

    // Predictor state
    logic [7:0] pend_line [LINE_DEPTH];
    int         pend_fill;
    logic [2:0] mode_now;

    logic [7:0] byte_queue [$];
    report_t    report_queue [$];
    int         errors;
    int         sent_count;
    int         report_count;
    int         line_count;
    int         long_count;
    int         cycles;
    bit         calm;
    bit         hold_long;
    bit         hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit instant_letter(input logic [7:0] c);
        logic [7:0] u;
        u = upcase(c);
        return u == "F" || u == "B" || u == "L" || u == "R" ||
               u == "T" || u == "C" || u == "X";
    endfunction

    // Case-blind match of a trimmed span against a keyword
    function automatic bit word_is(input logic [7:0] buf_in [LINE_DEPTH], input int s,
                                   input int n, input string w);
        if (n != w.len())
            return 0;
        for (int i = 0; i < n; i++)
            if (upcase(buf_in[s + i]) != w[i])
                return 0;
        return 1;
    endfunction

    function automatic void steer(input logic [2:0] m, inout report_t r);
        r.changed = (mode_now != m);
        mode_now = m;
        r.act = uclp_pkg::ACT_DRIVE;
    endfunction

    // Decode one flushed line and update the mode
    function automatic report_t decode_line(input logic [7:0] b [LINE_DEPTH], input int n);
        report_t r;
        int len, s, e, tl;
        bit comma;
        len = 0;
        comma = 0;
        r = '0;
        while (len < n && b[len] != uclp_pkg::CHR_NUL)
            len++;
        s = 0;
        while (s < len && blank_char(b[s]))
            s++;
        e = len;
        while (e > s && blank_char(b[e - 1]))
            e--;
        tl = e - s;
        for (int k = 1; k < tl; k++)
            if (b[s + k] == uclp_pkg::CHR_COMMA)
                comma = 1;
        if (tl == 0)
            r.act = uclp_pkg::ACT_BLANK;
        else if (word_is(b, s, tl, "PING"))
            r.act = uclp_pkg::ACT_PONG;
        else if (word_is(b, s, tl, "HELP") || word_is(b, s, tl, "?"))
            r.act = uclp_pkg::ACT_HELP;
        else if (b[s] == uclp_pkg::CHR_DOLLAR && comma)
            r.act = uclp_pkg::ACT_SENTENCE;
        else if (word_is(b, s, tl, "Q") || word_is(b, s, tl, "STATUS"))
            r.act = uclp_pkg::ACT_STATUS;
        else if (word_is(b, s, tl, "STOP") || word_is(b, s, tl, "X")
                 || word_is(b, s, tl, "0"))
            steer(uclp_pkg::MODE_STOP, r);
        else if (word_is(b, s, tl, "F") || word_is(b, s, tl, "FORWARD"))
            steer(uclp_pkg::MODE_FORWARD, r);
        else if (word_is(b, s, tl, "B") || word_is(b, s, tl, "BACK")
                 || word_is(b, s, tl, "BACKWARD") || word_is(b, s, tl, "REVERSE"))
            steer(uclp_pkg::MODE_REVERSE, r);
        else if (word_is(b, s, tl, "L") || word_is(b, s, tl, "LEFT"))
            steer(uclp_pkg::MODE_LEFT, r);
        else if (word_is(b, s, tl, "R") || word_is(b, s, tl, "RIGHT"))
            steer(uclp_pkg::MODE_RIGHT, r);
        else if (word_is(b, s, tl, "T") || word_is(b, s, tl, "PINTEST")
                 || word_is(b, s, tl, "GPIOTEST"))
        begin
            mode_now = uclp_pkg::MODE_STOP;
            r.act = uclp_pkg::ACT_PIN;
        end
        else if (word_is(b, s, tl, "C") || word_is(b, s, tl, "MAPTEST")
                 || word_is(b, s, tl, "PINMAP") || word_is(b, s, tl, "M"))
        begin
            mode_now = uclp_pkg::MODE_STOP;
            r.act = uclp_pkg::ACT_MAP;
        end
        else
            r.act = uclp_pkg::ACT_UNKNOWN;
        r.mode = mode_now;
        r.last = 1'b0;
        return r;
    endfunction

    // Work out the reports caused by one accepted byte
    function automatic void predict_byte(input logic [7:0] c);
        report_t got [$];
        report_t r;
        logic [7:0] one [LINE_DEPTH];
        one[0] = c;
        if (instant_letter(c))
        begin
            if (pend_fill != 0)
            begin
                got.push_back(decode_line(pend_line, pend_fill));
                pend_fill = 0;
            end
            got.push_back(decode_line(one, 1));
        end
        else if (pend_fill == 0 && c == uclp_pkg::CHR_ZERO)
            got.push_back(decode_line(one, 1));
        else if (c == uclp_pkg::CHR_CR || c == uclp_pkg::CHR_LF)
        begin
            if (pend_fill != 0)
            begin
                got.push_back(decode_line(pend_line, pend_fill));
                pend_fill = 0;
            end
        end
        else if (pend_fill < LINE_DEPTH - 1)
        begin
            pend_line[pend_fill] = c;
            pend_fill++;
        end
        else
        begin
            pend_fill = 0;
            r = '0;
            r.act = uclp_pkg::ACT_LONG;
            r.mode = mode_now;
            got.push_back(r);
            long_count++;
        end
        if (got.size() > 0)
            got[got.size() - 1].last = 1'b1;
        foreach (got[i])
            report_queue.push_back(got[i]);
    endfunction

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    // Random byte biased towards parser-relevant characters
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return " ";
            2: return uclp_pkg::CHR_COMMA;
            3: return 8'($urandom_range(8'h09, 8'h0D));
            4: return uclp_pkg::CHR_NUL;
            default: return 8'($urandom_range("A", "z"));
        endcase
    endfunction

    // Turn upper case letters to lower case at random
    function automatic string mix_case(input string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(0, 1))
                t[i] = t[i] + 8'd32;
        return t;
    endfunction

    // Fill the stimulus queue
    initial
    begin
        string words [] = '{"PING", "HELP", "?", "Q", "STATUS", "STOP", "0", "BACK",
                            "LEFT", "RIGHT", "PINTEST", "GPIOTEST", "MAPTEST",
                            "PINMAP", "M", "FOO", "$GP,1", "$", "PINGS", "?? "};
        string letters = "FBLRTCXfblrtcx";
        string w;
        // directed part
        send_text("ping\r");
        send_text(" Help \n");
        send_text("\r");
        send_text("0");
        send_text(" \t\n");
        send_text("$GPGGA,1\n");
        send_text("q\r");
        send_text("FfBbLlRrXxTtCc");
        send_text("stat");
        send_text("F");
        send_text("Mq");
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(uclp_pkg::CHR_NUL);
        send_text("junk\n");
        for (int i = 0; i < LINE_DEPTH; i++)
            byte_queue.push_back("a");
        // random part
        while (byte_queue.size() < 800 - LINE_DEPTH - 8)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    w = words[$urandom_range(0, words.size() - 1)];
                    if ($urandom_range(0, 2) == 0)
                        w = {" ", w, "  "};
                    send_text(mix_case(w));
                    byte_queue.push_back($urandom_range(0, 1) ? uclp_pkg::CHR_CR
                                                              : uclp_pkg::CHR_LF);
                end
                5, 6:
                    byte_queue.push_back(letters[$urandom_range(0, letters.len() - 1)]);
                7:
                    repeat ($urandom_range(1, 6))
                        byte_queue.push_back(noise_byte());
                8:
                    byte_queue.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    send_text(mix_case(words[$urandom_range(0, words.size() - 1)]));
                    byte_queue.push_back(noise_byte());
                    byte_queue.push_back(uclp_pkg::CHR_LF);
                end
            endcase
        end
        // a long random run of letters late in the run
        for (int i = 0; i < LINE_DEPTH; i++)
            byte_queue.push_back(8'($urandom_range("D", "K")));
        send_text("\nSTATUS\r");
    end

    // Reset and run control
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (byte_queue.size() == 0 && !in_valid);
        wait (report_queue.size() == 0);
        repeat (300) @(posedge clk);
        if (report_queue.size() != 0)
            errors++;
        $display("Sent %0d bytes, checked %0d reports, %0d lines over length.",
                 sent_count, report_count, long_count);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Count cycles and stop on timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout at %0t", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        pend_fill = 0;
        mode_now = uclp_pkg::MODE_STOP;
        errors = 0;
        sent_count = 0;
        report_count = 0;
        long_count = 0;
        cycles = 0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        out_stall = 1'b0;
        hold_done = 1'b0;
    end

    // Sender: offer items with random gaps
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap <= 0;
        end
        else
        begin
            calm = byte_queue.size() < 120;
            if (in_valid && !in_stall)
            begin
                predict_byte(rx_byte);
                sent_count++;
            end
            if (in_valid && in_stall)
                ;
            else if (gap > 0)
            begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() > 0 && (calm || $urandom_range(0, 9) != 0))
            begin
                in_valid <= 1'b1;
                rx_byte <= byte_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                if (byte_queue.size() > 0 && !calm)
                    gap <= $urandom_range(1, 18);
            end
        end
    end

    // Receiver: random stall bursts and one long hold-off
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (!hold_done && sent_count > 40)
        begin
            hold_done <= 1'b1;
            out_stall <= 1'b1;
            stall_left <= 600;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: compare each taken report with the oldest prediction
    report_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            report_count++;
            if (report_queue.size() == 0)
            begin
                $display("%0t: unexpected report action=%0d mode=%0d", $time,
                         action, drive_mode);
                errors++;
            end
            else
            begin
                want = report_queue.pop_front();
                if (action !== want.act)
                begin
                    $display("%0t: action expected %0d actual %0d", $time, want.act, action);
                    errors++;
                end
                if (drive_mode !== want.mode)
                begin
                    $display("%0t: drive_mode expected %0d actual %0d", $time,
                             want.mode, drive_mode);
                    errors++;
                end
                if (mode_changed !== want.changed)
                begin
                    $display("%0t: mode_changed expected %0d actual %0d", $time,
                             want.changed, mode_changed);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result expected %0d actual %0d", $time,
                             want.last, last_result);
                    errors++;
                end
            end
        end
    end

endmodule
